FILE: rtl/ecr_pkg.sv
// Shared types and constants for the elastic collision response block.
package ecr_pkg;

	// Field widths of one colliding pair and of one response.
	localparam int unsigned VEL_W  = 16;
	localparam int unsigned POS_W  = 24;
	localparam int unsigned MASS_W = 16;

	// Velocity components handled side by side: first x, first y, second x, second y.
	localparam int unsigned LANES = 4;
	localparam int unsigned LANE_FIRST_X  = 0;
	localparam int unsigned LANE_FIRST_Y  = 1;
	localparam int unsigned LANE_SECOND_X = 2;
	localparam int unsigned LANE_SECOND_Y = 3;

	// Arithmetic widths of the collision formula.
	localparam int unsigned DIFF_W = MASS_W + 1;          // signed mass difference
	localparam int unsigned SUM_W  = MASS_W + 1;          // unsigned mass sum
	localparam int unsigned PROD_W = VEL_W + DIFF_W;      // velocity times mass
	localparam int unsigned NUM_W  = PROD_W + 1;          // numerator
	localparam int unsigned REM_W  = NUM_W - 1;           // numerator magnitude
	localparam int unsigned QUO_W  = VEL_W;               // quotient bits produced
	localparam int unsigned DV_W   = VEL_W + 1;           // velocity difference
	localparam int unsigned DP_W   = POS_W + 1;           // position difference
	localparam int unsigned DOTP_W = DV_W + DP_W;         // one dot product term
	localparam int unsigned DOT_W  = DOTP_W + 1;          // full dot product

	// Saturation limits of a signed velocity.
	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	// One colliding pair.
	typedef struct packed {
		logic signed [VEL_W-1:0]  first_vel_x;
		logic signed [VEL_W-1:0]  first_vel_y;
		logic signed [VEL_W-1:0]  second_vel_x;
		logic signed [VEL_W-1:0]  second_vel_y;
		logic signed [POS_W-1:0]  first_pos_x;
		logic signed [POS_W-1:0]  first_pos_y;
		logic signed [POS_W-1:0]  second_pos_x;
		logic signed [POS_W-1:0]  second_pos_y;
		logic        [MASS_W-1:0] first_mass;
		logic        [MASS_W-1:0] second_mass;
	} ecr_pair_t;

	// One collision response.
	typedef struct packed {
		logic signed [VEL_W-1:0] first_new_vel_x;
		logic signed [VEL_W-1:0] first_new_vel_y;
		logic signed [VEL_W-1:0] second_new_vel_x;
		logic signed [VEL_W-1:0] second_new_vel_y;
		logic                    response_applied;
	} ecr_resp_t;

	// Division state of one velocity component.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} ecr_lane_t;

	// Item traveling through the divider pipeline.
	typedef struct packed {
		ecr_lane_t [LANES-1:0]            lane;
		logic [SUM_W-1:0]                 sum;
		logic                             applied;
		logic [LANES-1:0][VEL_W-1:0]      vel;
	} ecr_div_t;

endpackage

FILE: rtl/ecr_if.sv
// Valid/ready channel interfaces for colliding pairs and responses.
interface ecr_pair_if import ecr_pkg::*; ();
	logic      valid;
	logic      ready;
	ecr_pair_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ecr_resp_if import ecr_pkg::*; ();
	logic      valid;
	logic      ready;
	ecr_resp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ecr_front.sv
// Front stages: differences, products, numerators, dot product sign and magnitudes.
module ecr_front import ecr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  ecr_pair_t in_data,
	output logic      out_valid,
	output ecr_div_t  out_item
);

	// Stage 1 registers.
	logic                       valid_s1;
	logic signed [VEL_W-1:0]    u_s1 [LANES];
	logic signed [DV_W-1:0]     dvx_s1, dvy_s1;
	logic signed [DP_W-1:0]     dpx_s1, dpy_s1;
	logic signed [DIFF_W-1:0]   dm_s1;
	logic        [MASS_W-1:0]   m1_s1, m2_s1;
	logic        [SUM_W-1:0]    sum_s1;

	// Stage 2 registers.
	logic                       valid_s2;
	logic signed [VEL_W-1:0]    u_s2 [LANES];
	logic signed [DOTP_W-1:0]   dotx_s2, doty_s2;
	logic signed [PROD_W-1:0]   a_s2 [LANES];
	logic signed [PROD_W-1:0]   b_s2 [LANES];
	logic        [SUM_W-1:0]    sum_s2;

	// Stage 3 registers.
	logic                       valid_s3;
	logic signed [VEL_W-1:0]    u_s3 [LANES];
	logic signed [NUM_W-1:0]    num_s3 [LANES];
	logic                       applied_s3;
	logic        [SUM_W-1:0]    sum_s3;

	// Stage 4 register.
	logic                       valid_s4;
	ecr_div_t                   item_s4;

	logic signed [DOT_W-1:0]    dot;
	logic signed [NUM_W-1:0]    num [LANES];
	ecr_div_t                   item_nxt;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: relative velocity, relative position, mass difference and sum.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[LANE_FIRST_X]  <= in_data.first_vel_x;
			u_s1[LANE_FIRST_Y]  <= in_data.first_vel_y;
			u_s1[LANE_SECOND_X] <= in_data.second_vel_x;
			u_s1[LANE_SECOND_Y] <= in_data.second_vel_y;
			dvx_s1 <= DV_W'(in_data.first_vel_x) - DV_W'(in_data.second_vel_x);
			dvy_s1 <= DV_W'(in_data.first_vel_y) - DV_W'(in_data.second_vel_y);
			dpx_s1 <= DP_W'(in_data.first_pos_x) - DP_W'(in_data.second_pos_x);
			dpy_s1 <= DP_W'(in_data.first_pos_y) - DP_W'(in_data.second_pos_y);
			dm_s1  <= $signed({1'b0, in_data.first_mass}) - $signed({1'b0, in_data.second_mass});
			sum_s1 <= {1'b0, in_data.first_mass} + {1'b0, in_data.second_mass};
			m1_s1  <= in_data.first_mass;
			m2_s1  <= in_data.second_mass;
		end
	end

	// Stage 2: one multiplier per product term.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s2    <= u_s1;
			sum_s2  <= sum_s1;
			dotx_s2 <= dvx_s1 * dpx_s1;
			doty_s2 <= dvy_s1 * dpy_s1;
			for (int k = 0; k < LANES; k++) begin
				a_s2[k] <= u_s1[k] * dm_s1;
			end
			b_s2[LANE_FIRST_X]  <= $signed({1'b0, m2_s1}) * u_s1[LANE_SECOND_X];
			b_s2[LANE_FIRST_Y]  <= $signed({1'b0, m2_s1}) * u_s1[LANE_SECOND_Y];
			b_s2[LANE_SECOND_X] <= $signed({1'b0, m1_s1}) * u_s1[LANE_FIRST_X];
			b_s2[LANE_SECOND_Y] <= $signed({1'b0, m1_s1}) * u_s1[LANE_FIRST_Y];
		end
	end

	// Stage 3 logic: dot product and numerators. The second body sees the negated mass difference.
	always_comb begin
		dot = DOT_W'(dotx_s2) + DOT_W'(doty_s2);
		num[LANE_FIRST_X]  = NUM_W'(a_s2[LANE_FIRST_X]) + $signed({b_s2[LANE_FIRST_X], 1'b0});
		num[LANE_FIRST_Y]  = NUM_W'(a_s2[LANE_FIRST_Y]) + $signed({b_s2[LANE_FIRST_Y], 1'b0});
		num[LANE_SECOND_X] = $signed({b_s2[LANE_SECOND_X], 1'b0}) - NUM_W'(a_s2[LANE_SECOND_X]);
		num[LANE_SECOND_Y] = $signed({b_s2[LANE_SECOND_Y], 1'b0}) - NUM_W'(a_s2[LANE_SECOND_Y]);
	end

	// Stage 3: the response applies when the bodies approach (dot product not positive) and the mass sum is nonzero.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s3       <= u_s2;
			sum_s3     <= sum_s2;
			num_s3     <= num;
			applied_s3 <= (dot[DOT_W-1] || (dot == '0)) && (sum_s2 != '0);
		end
	end

	// Stage 4 logic: sign, magnitude and early overflow check of each quotient.
	always_comb begin
		logic [NUM_W-1:0] mag;
		item_nxt.sum     = sum_s3;
		item_nxt.applied = applied_s3;
		for (int k = 0; k < LANES; k++) begin
			mag = num_s3[k][NUM_W-1] ? NUM_W'(-num_s3[k]) : NUM_W'(num_s3[k]);
			item_nxt.vel[k]      = u_s3[k];
			item_nxt.lane[k].neg = num_s3[k][NUM_W-1];
			item_nxt.lane[k].rem = mag[REM_W-1:0];
			item_nxt.lane[k].quo = '0;
			item_nxt.lane[k].ovf = mag[REM_W-1:0] >= {sum_s3, {QUO_W{1'b0}}};
		end
	end

	// Stage 4 register.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= item_nxt;
		end
	end

	assign out_valid = valid_s4;
	assign out_item  = item_s4;

endmodule

FILE: rtl/ecr_divider.sv
// Pipelined restoring divider: one quotient bit per stage for all four components.
module ecr_divider import ecr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  ecr_div_t in_item,
	output logic     out_valid,
	output ecr_div_t out_item
);

	// Entry g holds the item after quotient bit QUO_W-1-g has been settled.
	ecr_div_t stage_s [QUO_W];
	logic     valid_s [QUO_W];
	ecr_div_t prev_item [QUO_W];
	logic     prev_valid [QUO_W];

	for (genvar g = 0; g < QUO_W; g++) begin : g_step
		localparam int unsigned SHIFT = QUO_W - 1 - g;
		ecr_div_t nxt;

		if (g == 0) begin : g_first
			assign prev_item[g]  = in_item;
			assign prev_valid[g] = in_valid;
		end else begin : g_rest
			assign prev_item[g]  = stage_s[g-1];
			assign prev_valid[g] = valid_s[g-1];
		end

		// Trial subtraction of the shifted divisor from each remainder.
		always_comb begin
			logic [REM_W-1:0] dvs;
			logic [REM_W:0]   diff;
			nxt = prev_item[g];
			dvs = REM_W'(prev_item[g].sum) << SHIFT;
			for (int k = 0; k < LANES; k++) begin
				diff = {1'b0, prev_item[g].lane[k].rem} - {1'b0, dvs};
				if (!diff[REM_W]) begin
					nxt.lane[k].rem        = diff[REM_W-1:0];
					nxt.lane[k].quo[SHIFT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (en) begin
				valid_s[g] <= prev_valid[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[g] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[QUO_W-1];
	assign out_item  = stage_s[QUO_W-1];

endmodule

FILE: rtl/ecr_back.sv
// Final stage: sign, saturation, pass-through select and the output register.
module ecr_back import ecr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ecr_div_t  in_item,
	input  logic      out_ready,
	output logic      en,
	output logic      out_valid,
	output ecr_resp_t out_data
);

	logic      resp_valid_q;
	ecr_resp_t resp_q;
	logic [LANES-1:0][VEL_W-1:0] vel;

	// The whole pipeline moves when the output register is empty or being taken.
	assign en = !resp_valid_q || out_ready;

	// Signed, saturated quotients, or the original velocities when no response applies.
	always_comb begin
		logic [QUO_W-1:0] q;
		logic             sat;
		for (int k = 0; k < LANES; k++) begin
			q = in_item.lane[k].quo;
			if (in_item.lane[k].neg) begin
				sat = in_item.lane[k].ovf || (q[QUO_W-1] && (q[QUO_W-2:0] != '0));
			end else begin
				sat = in_item.lane[k].ovf || q[QUO_W-1];
			end
			if (!in_item.applied) begin
				vel[k] = in_item.vel[k];
			end else if (sat) begin
				vel[k] = in_item.lane[k].neg ? VEL_MIN : VEL_MAX;
			end else begin
				vel[k] = in_item.lane[k].neg ? VEL_W'(-q) : VEL_W'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else if (en) begin
			resp_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			resp_q.first_new_vel_x  <= vel[LANE_FIRST_X];
			resp_q.first_new_vel_y  <= vel[LANE_FIRST_Y];
			resp_q.second_new_vel_x <= vel[LANE_SECOND_X];
			resp_q.second_new_vel_y <= vel[LANE_SECOND_Y];
			resp_q.response_applied <= in_item.applied;
		end
	end

	assign out_valid = resp_valid_q;
	assign out_data  = resp_q;

endmodule

FILE: rtl/elastic_collision_response.sv
// Elastic collision response for one pair of bodies per item, fully pipelined.
//
// Usage: colliding pairs arrive on pair_in (two velocities, two positions, two
// masses); one response leaves on resp_out for every pair, in order. Both are
// valid/ready channels; an item moves when valid and ready are high at a clock edge.
// When the relative velocity and relative position have a positive dot product,
// or both masses are zero, the velocities pass through and response_applied is 0.
// Otherwise each component gets the 1-D elastic formula, truncated toward zero
// and saturated to 16 bits.
// Pipeline: the response crosses 21 registers on its way to resp_out, the first
// loaded at the accepting edge: four front stages (differences, multipliers, sums,
// magnitudes), sixteen divider stages that each settle one quotient bit, and the
// output register.
// Throughput: one pair per cycle while not stalled; the divider settles one bit per stage.
// Stalls: when resp_out is held off with a result waiting, the pipeline freezes
// and pair_in.ready falls in the same cycle; nothing is lost or repeated.
// Reset: arst_n empties all stages at once; the block takes items right after.
module elastic_collision_response import ecr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ecr_pair_if.sink          pair_in,
	ecr_resp_if.source        resp_out
);

	logic      en;
	logic      front_valid;
	ecr_div_t  front_item;
	logic      div_valid;
	ecr_div_t  div_item;
	logic      resp_valid;
	ecr_resp_t resp_data;

	assign pair_in.ready = en;

	// Differences, products and numerator magnitudes.
	ecr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pair_in.valid),
		.in_data   (pair_in.data),
		.out_valid (front_valid),
		.out_item  (front_item)
	);

	// Quotients by the mass sum.
	ecr_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_item   (front_item),
		.out_valid (div_valid),
		.out_item  (div_item)
	);

	// Saturation and output register.
	ecr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_item   (div_item),
		.out_ready (resp_out.ready),
		.en        (en),
		.out_valid (resp_valid),
		.out_data  (resp_data)
	);

	assign resp_out.valid = resp_valid;
	assign resp_out.data  = resp_data;

endmodule
